FILE: hdl/batched_id_allocator_assert.svh
// Assertion macros for the batched ID allocator.
`ifndef BATCHED_ID_ALLOCATOR_ASSERT_SVH
`define BATCHED_ID_ALLOCATOR_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define BIA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Consequent that must hold in the same cycle as the antecedent.
`define BIA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bia_pkg.sv
// Shared types and constants for the batched ID allocator.
package bia_pkg;

    localparam int ID_SPACE    = 1024;
    localparam int ID_W        = 10;
    localparam int CNT_W       = 11;
    localparam int BATCH_W     = 7;
    localparam int BATCH_MAX   = 64;
    localparam int BATCH_RESET = 16;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int TDATA_W     = 16;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = 1;
    localparam int FIFO_CNT_W  = 2;

    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_ALLOCATED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EXHAUSTED     = 2'd2;

    typedef enum logic [1:0] {
        K_ALLOC,
        K_RELEASE,
        K_CLEAR,
        K_NOP
    } bia_kind_t;

    typedef struct packed {
        bia_kind_t       kind;
        logic [ID_W-1:0] id;
    } bia_op_t;

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_QREAD,
        S_MREAD
    } bia_state_t;

    typedef struct packed {
        logic [CNT_W-1:0]   queue_count;
        logic [CNT_W-1:0]   next_fresh;
        logic [BATCH_W-1:0] fresh_left;
    } bia_stat_t;

endpackage

FILE: hdl/bia_fifo.sv
// Short request queue between the front and back parts of the allocator.
module bia_fifo
    import bia_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bia_op_t push_op,
    output logic    full,
    input  logic    pop,
    output bia_op_t pop_op,
    output logic    empty
);

    bia_op_t                 entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                    do_push, do_pop;

    assign full    = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_op  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

FILE: hdl/bia_front.sv
// Input stage: accepts requests and classifies them into operations.
module bia_front
    import bia_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TDATA_W-1:0]  s_tdata,   // [9:0] release_id, rest zero
    input  logic [MODE_W-1:0]   s_tuser,   // [1:0] mode
    output logic                push,
    output bia_op_t             push_op,
    input  logic                fifo_full
);

    logic    valid_reg, valid_next;
    bia_op_t op_reg, op_next;
    logic    accept;

    assign s_tready = !valid_reg || !fifo_full;
    assign accept   = s_tvalid && s_tready;
    assign push     = valid_reg;
    assign push_op  = op_reg;

    always_comb begin
        op_next    = op_reg;
        valid_next = valid_reg;
        if (valid_reg && !fifo_full) begin
            valid_next = 1'b0;
        end
        if (accept) begin
            valid_next = 1'b1;
            op_next.id = s_tdata[ID_W-1:0];
            unique case (s_tuser)
                MODE_ALLOC:   op_next.kind = K_ALLOC;
                MODE_RELEASE: op_next.kind = K_RELEASE;
                MODE_CLEAR:   op_next.kind = K_CLEAR;
                default:      op_next.kind = K_NOP;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next;
    end

endmodule

FILE: hdl/bia_back.sv
// Execution stage: free queue, allocation bitmap, fresh range and result register.
module bia_back
    import bia_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [BATCH_W-1:0]  batch_size,
    input  bia_op_t             op,
    input  logic                op_empty,
    output logic                op_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // [9:0] granted_id, rest zero
    output logic [STATUS_W-1:0] m_tuser,   // [1:0] status
    output bia_stat_t           stat
);

    bia_state_t          state_reg, state_next;
    logic [ID_W-1:0]     sweep_reg, sweep_next;
    logic [ID_W-1:0]     head_reg, head_next;
    logic [ID_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    fresh_reg, fresh_next;
    logic [BATCH_W-1:0]  left_reg, left_next;
    logic [ID_W-1:0]     rel_id_reg, rel_id_next;
    logic                m_valid_reg, m_valid_next;
    logic [ID_W-1:0]     m_id_reg, m_id_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;

    logic [ID_W-1:0]     queue_mem [ID_SPACE];
    logic                map_mem   [ID_SPACE];
    logic                q_we, q_re, map_we, map_re;
    logic [ID_W-1:0]     q_waddr, q_raddr, q_wdata, q_rdata_reg;
    logic [ID_W-1:0]     map_waddr, map_raddr;
    logic                map_wdata, map_rdata_reg;

    logic                out_free, pop;
    logic                use_fresh, from_queue, rel_in_range, sweep_last;
    logic [CNT_W-1:0]    room;
    logic [BATCH_W-1:0]  bs_clamp, batch_n;

    function automatic logic [ID_W-1:0] ring_next(input logic [ID_W-1:0] p);
        ring_next = (p == ID_W'(ID_SPACE - 1)) ? '0 : p + 1'b1;
    endfunction

    assign out_free     = !m_valid_reg || m_tready;
    assign pop          = (state_reg == S_IDLE) && !op_empty && out_free;
    assign op_pop       = pop;
    assign use_fresh    = (left_reg != '0) || (count_reg == '0);
    assign from_queue   = (op.kind == K_ALLOC) && !use_fresh;
    assign rel_in_range = CNT_W'(op.id) < CNT_W'(ID_SPACE);
    assign sweep_last   = (sweep_reg == ID_W'(ID_SPACE - 1));
    assign room         = CNT_W'(ID_SPACE) - fresh_reg;

    always_comb begin
        if (batch_size == '0) begin
            bs_clamp = BATCH_W'(1);
        end else if (batch_size > BATCH_W'(BATCH_MAX)) begin
            bs_clamp = BATCH_W'(BATCH_MAX);
        end else begin
            bs_clamp = batch_size;
        end
        batch_n = (CNT_W'(bs_clamp) > room) ? room[BATCH_W-1:0] : bs_clamp;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_SWEEP: begin
                if (sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (pop) begin
                    case (op.kind)
                        K_ALLOC:   state_next = from_queue ? S_QREAD : S_IDLE;
                        K_RELEASE: state_next = rel_in_range ? S_MREAD : S_IDLE;
                        K_CLEAR:   state_next = S_SWEEP;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_QREAD: state_next = S_IDLE;
            S_MREAD: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        sweep_next    = sweep_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        fresh_next    = fresh_reg;
        left_next     = left_reg;
        rel_id_next   = rel_id_reg;
        m_valid_next  = m_tready ? 1'b0 : m_valid_reg;
        m_id_next     = m_id_reg;
        m_status_next = m_status_reg;
        q_we          = 1'b0;
        q_waddr       = tail_reg;
        q_wdata       = rel_id_reg;
        q_re          = 1'b0;
        q_raddr       = head_reg;
        map_we        = 1'b0;
        map_waddr     = sweep_reg;
        map_wdata     = 1'b0;
        map_re        = 1'b0;
        map_raddr     = op.id;
        unique case (state_reg)
            S_SWEEP: begin
                map_we     = 1'b1;
                sweep_next = sweep_reg + 1'b1;
            end
            S_IDLE: begin
                if (pop) begin
                    m_id_next     = '0;
                    m_status_next = STAT_OK;
                    case (op.kind)
                        K_ALLOC: begin
                            if (from_queue) begin
                                q_re       = 1'b1;
                                head_next  = ring_next(head_reg);
                                count_next = count_reg - 1'b1;
                            end else if (left_reg == '0 && batch_n == '0) begin
                                m_valid_next  = 1'b1;
                                m_status_next = STAT_EXHAUSTED;
                            end else begin
                                map_we       = 1'b1;
                                map_waddr    = fresh_reg[ID_W-1:0];
                                map_wdata    = 1'b1;
                                fresh_next   = fresh_reg + 1'b1;
                                left_next    = ((left_reg != '0) ? left_reg : batch_n) - 1'b1;
                                m_valid_next = 1'b1;
                                m_id_next    = fresh_reg[ID_W-1:0];
                            end
                        end
                        K_RELEASE: begin
                            if (rel_in_range) begin
                                map_re      = 1'b1;
                                rel_id_next = op.id;
                            end else begin
                                m_valid_next  = 1'b1;
                                m_status_next = STAT_NOT_ALLOCATED;
                            end
                        end
                        K_CLEAR: begin
                            head_next    = '0;
                            tail_next    = '0;
                            count_next   = '0;
                            fresh_next   = '0;
                            left_next    = '0;
                            sweep_next   = '0;
                            m_valid_next = 1'b1;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_QREAD: begin
                map_we        = 1'b1;
                map_waddr     = q_rdata_reg;
                map_wdata     = 1'b1;
                m_valid_next  = 1'b1;
                m_id_next     = q_rdata_reg;
                m_status_next = STAT_OK;
            end
            S_MREAD: begin
                m_valid_next = 1'b1;
                m_id_next    = '0;
                if (map_rdata_reg) begin
                    map_we        = 1'b1;
                    map_waddr     = rel_id_reg;
                    map_wdata     = 1'b0;
                    m_status_next = STAT_OK;
                    if (count_reg < CNT_W'(ID_SPACE)) begin
                        q_we       = 1'b1;
                        tail_next  = ring_next(tail_reg);
                        count_next = count_reg + 1'b1;
                    end
                end else begin
                    m_status_next = STAT_NOT_ALLOCATED;
                end
            end
            default: begin
                m_valid_next = m_valid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_SWEEP;
            sweep_reg   <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            fresh_reg   <= '0;
            left_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            fresh_reg   <= fresh_next;
            left_reg    <= left_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rel_id_reg   <= rel_id_next;
        m_id_reg     <= m_id_next;
        m_status_reg <= m_status_next;
    end

    always_ff @(posedge aclk) begin
        if (q_we) begin
            queue_mem[q_waddr] <= q_wdata;
        end
        if (q_re) begin
            q_rdata_reg <= queue_mem[q_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (map_re) begin
            map_rdata_reg <= map_mem[map_raddr];
        end
    end

    assign m_tvalid         = m_valid_reg;
    assign m_tdata          = {{(TDATA_W - ID_W){1'b0}}, m_id_reg};
    assign m_tuser          = m_status_reg;
    assign stat.queue_count = count_reg;
    assign stat.next_fresh  = fresh_reg;
    assign stat.fresh_left  = left_reg;

endmodule

FILE: hdl/batched_id_allocator.sv
// Top level of the batched ID allocator.
// Requests enter on s_tvalid/s_tready: s_tuser carries the mode (allocate, release,
// clear) and s_tdata the ID to give back. Every request gives exactly one result on
// m_tvalid/m_tready: m_tdata carries the granted ID and m_tuser the status.
// batch_size is written through cfg_wr_en/cfg_wr_data while the block is idle;
// the user must keep to this, as the block does not enforce it. A request passes
// an input register and a two-entry queue before the execution stage.
// In the execution stage an allocate from the fresh range completes in S_IDLE; an
// allocate from the free queue and an in-range release pass S_QREAD or S_MREAD,
// for the registered read of the free-queue memory or the allocation bitmap.
// After reset, and after every clear request, the bitmap is swept to zero over all
// 1024 entries; requests still queue up ahead of it, up to three deep.
// If the receiver stalls, the result register holds and execution stops; the
// queue and input register then fill and s_tready drops.
`include "batched_id_allocator_assert.svh"

module batched_id_allocator
    import bia_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [BATCH_W-1:0]  cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TDATA_W-1:0]  s_tdata,   // [9:0] release_id, rest zero
    input  logic [MODE_W-1:0]   s_tuser,   // [1:0] mode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,   // [9:0] granted_id, rest zero
    output logic [STATUS_W-1:0] m_tuser    // [1:0] status
);

    logic [BATCH_W-1:0] batch_size_reg, batch_size_next;
    logic               push, fifo_full, fifo_empty, fifo_pop;
    bia_op_t            push_op, pop_op;
    bia_stat_t          stat;
    logic [CNT_W:0]     fresh_end;
    logic               err_result;

    assign batch_size_next = cfg_wr_en ? cfg_wr_data : batch_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            batch_size_reg <= BATCH_W'(BATCH_RESET);
        end else begin
            batch_size_reg <= batch_size_next;
        end
    end

    bia_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (push),
        .push_op   (push_op),
        .fifo_full (fifo_full)
    );

    bia_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .full    (fifo_full),
        .pop     (fifo_pop),
        .pop_op  (pop_op),
        .empty   (fifo_empty)
    );

    bia_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .batch_size (batch_size_reg),
        .op         (pop_op),
        .op_empty   (fifo_empty),
        .op_pop     (fifo_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .stat       (stat)
    );

    assign fresh_end  = (CNT_W + 1)'(stat.next_fresh) + (CNT_W + 1)'(stat.fresh_left);
    assign err_result = m_tvalid && (m_tuser != STAT_OK);

    `BIA_ASSERT_ALWAYS(a_count_bound, stat.queue_count <= CNT_W'(ID_SPACE), "queue overfilled")
    `BIA_ASSERT_ALWAYS(a_fresh_bound, fresh_end <= (CNT_W + 1)'(ID_SPACE), "fresh range overrun")
    `BIA_ASSERT_IMPLY(a_err_zero_id, err_result, m_tdata == '0, "error with nonzero ID")

endmodule
